// ----- src/psde_pkg.sv -----
// Package for the per-slot dictionary encoder: opcode and status codes,
// the sequencer state type, the result record and the code width function.
// No dependencies.
package psde_pkg;

	// Item opcodes carried on the input side.
	localparam logic OP_LEARN  = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_ABSENT = 2'd2;

	// Field widths of one result beat.
	localparam int CODE_W   = 6;
	localparam int CWIDTH_W = 3;
	localparam int STATUS_W = 2;

	// Input pattern field width.
	localparam int PATTERN_FIELD_W = 32;

	// Sequencer states of the scan engine.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} psde_state_t;

	// One finished result as handed from the scan engine to the output stage.
	typedef struct packed {
		logic                was_present;
		logic [STATUS_W-1:0] status;
		logic [CWIDTH_W-1:0] code_width;
		logic [CODE_W-1:0]   code;
	} psde_res_t;

	// Number of binary digits of n, at least one.
	function automatic logic [4:0] bits_for(input logic [15:0] n);
		logic [4:0] w;
		w = 5'd1;
		for (int i = 0; i < 16; i++) begin
			if (n[i]) begin
				w = 5'(i + 1);
			end
		end
		return w;
	endfunction

endpackage

// ----- src/per_slot_dictionary_encoder.sv -----
// Top level of the per-slot dictionary encoder: stream ports and the output
// register. Depends on psde_pkg and psde_scan.
//
//   Channel  Direction  Beat contents
//   s_*      in         tuser: opcode; tdata: slot, pattern (40 bits)
//   m_*      out        tdata: code, code_width, status, was_present (16 bits)
//
// For an item, one stored pattern of its slot is read and compared each cycle
// through the single memory read port and comparator.
// Reset clears all entry counts at once; the pattern memory needs no clearing.
// The next item is accepted while a result waits in the output register; a
// stalled output holds the engine only when a second result is ready.
module per_slot_dictionary_encoder
	import psde_pkg::*;
#(
	parameter int SLOT_COUNT       = 4,
	parameter int ENTRIES_PER_SLOT = 64,
	parameter int PATTERN_WIDTH    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] slot, [33:2] pattern, rest zero
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [5:0] code, [8:6] code_width, [10:9] status,
	                               // [11] was_present, rest zero
);

	logic      engine_idle;
	logic      res_valid;
	logic      res_take;
	logic      start;
	psde_res_t res;
	logic      m_tvalid_q;
	psde_res_t out_q;

	// Input handshake.
	assign s_tready = engine_idle;
	assign start    = s_tvalid && engine_idle;

	// The output register is free when empty or being drained this cycle.
	assign res_take = !m_tvalid_q || m_tready;

	psde_scan #(
		.SLOT_COUNT      (SLOT_COUNT),
		.ENTRIES_PER_SLOT(ENTRIES_PER_SLOT),
		.PATTERN_WIDTH   (PATTERN_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.opcode   (s_tuser),
		.slot     (s_tdata[1:0]),
		.pattern  (s_tdata[33:2]),
		.res_take (res_take),
		.idle     (engine_idle),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output beat payload.
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, out_q.was_present, out_q.status, out_q.code_width, out_q.code};

endmodule

// ----- src/psde_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
module psde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/psde_scan.sv -----
// Scan engine: per-slot entry counts, the pattern memory and a sequencer that
// walks one slot's entries through a single comparator.
// Depends on psde_pkg and psde_ram.
module psde_scan
	import psde_pkg::*;
#(
	parameter int SLOT_COUNT       = 4,
	parameter int ENTRIES_PER_SLOT = 64,
	parameter int PATTERN_WIDTH    = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       opcode,
	input  logic [1:0]                 slot,
	input  logic [PATTERN_FIELD_W-1:0] pattern,
	input  logic                       res_take,
	output logic                       idle,
	output logic                       res_valid,
	output psde_res_t                  res
);

	localparam int IDX_W   = $clog2(ENTRIES_PER_SLOT);
	localparam int CNT_W   = $clog2(ENTRIES_PER_SLOT + 1);
	localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ADDR_W  = SLOT_W + IDX_W;
	localparam int STORE_W = (PATTERN_WIDTH < PATTERN_FIELD_W) ? PATTERN_WIDTH
		: PATTERN_FIELD_W;

	psde_state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q [SLOT_COUNT];
	logic               op_q;
	logic [SLOT_W-1:0]  slot_idx_q;
	logic [STORE_W-1:0] pat_q;
	logic [CNT_W-1:0]   issue_q;
	logic               pend_v_q;
	logic [IDX_W-1:0]   pend_idx_q;
	psde_res_t          res_q;

	logic               slot_ok;
	logic [SLOT_W-1:0]  slot_idx;
	logic [CNT_W-1:0]   cnt_cur;
	logic [CNT_W-1:0]   cnt_final;
	logic [CWIDTH_W-1:0] width_now;
	logic [STORE_W-1:0] rd_data;
	logic               hit;
	logic               at_end;
	logic               issue_en;
	logic               fin_hit;
	logic               fin_miss;
	logic               fin_bad;
	logic               cnt_inc;

	// Decode of the incoming slot number.
	assign slot_ok  = (int'(slot) < SLOT_COUNT);
	assign slot_idx = SLOT_W'(slot);

	// Count of the slot under scan and the count after this item.
	assign cnt_cur   = count_q[slot_idx_q];
	assign cnt_final = cnt_inc ? cnt_cur + CNT_W'(1) : cnt_cur;
	assign width_now = CWIDTH_W'(bits_for(16'(cnt_final)));

	// The single comparator and the end-of-scan test.
	assign hit    = pend_v_q && (rd_data == pat_q);
	assign at_end = (issue_q == cnt_cur);

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// Pattern memory, one region per slot.
	psde_ram #(
		.WIDTH(STORE_W),
		.DEPTH(2 ** ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (cnt_inc),
		.waddr({slot_idx_q, cnt_cur[IDX_W-1:0]}),
		.wdata(pat_q),
		.re   (issue_en),
		.raddr({slot_idx_q, issue_q[IDX_W-1:0]}),
		.rdata(rd_data)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer controls.
	always_comb begin
		state_d  = state_q;
		issue_en = 1'b0;
		fin_hit  = 1'b0;
		fin_miss = 1'b0;
		fin_bad  = 1'b0;
		cnt_inc  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (slot_ok) begin
						state_d = ST_SCAN;
					end else begin
						fin_bad = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					fin_hit = 1'b1;
					state_d = ST_DONE;
				end else if (at_end && !pend_v_q) begin
					fin_miss = 1'b1;
					state_d  = ST_DONE;
					if (op_q == OP_LEARN && cnt_cur != CNT_W'(ENTRIES_PER_SLOT)) begin
						cnt_inc = 1'b1;
					end
				end else begin
					issue_en = !at_end;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Scan position and entry counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= '0;
			pend_v_q <= 1'b0;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				count_q[s] <= '0;
			end
		end else begin
			if (start && state_q == ST_IDLE) begin
				issue_q  <= '0;
				pend_v_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_v_q <= issue_en;
				if (issue_en) begin
					issue_q <= issue_q + CNT_W'(1);
				end
			end
			if (cnt_inc) begin
				count_q[slot_idx_q] <= cnt_final;
			end
		end
	end

	// Item fields, pending index and the finished result.
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			op_q       <= opcode;
			slot_idx_q <= slot_idx;
			pat_q      <= pattern[STORE_W-1:0];
		end
		if (issue_en) begin
			pend_idx_q <= issue_q[IDX_W-1:0];
		end
		if (fin_bad) begin
			res_q.code        <= '0;
			res_q.code_width  <= CWIDTH_W'(1);
			res_q.status      <= (opcode == OP_ENCODE) ? STATUS_ABSENT : STATUS_FULL;
			res_q.was_present <= 1'b0;
		end else if (fin_hit) begin
			res_q.code        <= CODE_W'(pend_idx_q);
			res_q.code_width  <= width_now;
			res_q.status      <= STATUS_OK;
			res_q.was_present <= 1'b1;
		end else if (fin_miss) begin
			res_q.code_width  <= width_now;
			res_q.was_present <= 1'b0;
			if (cnt_inc) begin
				res_q.code   <= CODE_W'(cnt_cur);
				res_q.status <= STATUS_OK;
			end else begin
				res_q.code   <= '0;
				res_q.status <= (op_q == OP_ENCODE) ? STATUS_ABSENT : STATUS_FULL;
			end
		end
	end

endmodule
